[rtl/assert_macros.svh]
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables the check
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset disables the check
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/chtd_pkg.sv]
// package: types, constants and helper functions of the decode unit
package chtd_pkg;

  localparam logic [7:0]  CrcInit    = 8'hFF;
  localparam logic [7:0]  PolyReset  = 8'h31;
  localparam logic [10:0] TempScale  = 11'd1750;
  localparam logic [26:0] TempOffset = 27'd29490750;
  localparam logic [9:0]  HumScale   = 10'd1000;

  // one received sensor frame
  typedef struct packed {
    logic [7:0] t_hi;
    logic [7:0] t_lo;
    logic [7:0] t_chk;
    logic [7:0] h_hi;
    logic [7:0] h_lo;
    logic [7:0] h_chk;
  } chtd_frame_t;

  // frame after the first pass: partial crcs and scaled words
  typedef struct packed {
    logic [7:0]  t_crc;
    logic [7:0]  t_lo;
    logic [7:0]  t_chk;
    logic [7:0]  h_crc;
    logic [7:0]  h_lo;
    logic [7:0]  h_chk;
    logic [26:0] t_scaled;
    logic [25:0] h_scaled;
  } chtd_mid_t;

  // decoded result as held in the output register
  typedef struct packed {
    logic              temp_positive;
    logic [10:0]       temp_magnitude;
    logic signed [11:0] temp_signed;
    logic [9:0]        humidity;
    logic              temp_ok;
    logic              hum_ok;
  } chtd_res_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      crc = {crc[6:0], 1'b0} ^ (poly & {8{crc[7]}});
    end
    return crc;
  endfunction

  // floor(x / 65535) for quotients well below 65536
  function automatic logic [11:0] div_full_scale(input logic [26:0] x);
    logic [27:0] s;
    s = 28'(x) + 28'(x[26:16]) + 28'd1;
    return s[27:16];
  endfunction

endpackage

[rtl/crc_checked_humidity_temperature_decode_unit.sv]
// top level of the crc-checked humidity and temperature decode unit
//
//  channel   handshake                  payload
//  input     in_valid_i / in_ready_o    six frame bytes
//  result    out_valid_o / out_ready_i  sign, magnitude, signed, humidity, crc flags
//  config    cfg_we_i                   cfg_wdata_i (crc polynomial)
//
// three register stages (input, crc/multiply, output): a request passes through
// them in that order, and one frame is taken every cycle while the output is not stalled.
// reset sets the polynomial to 0x31 and clears held values and valid flags.
// a stalled output only holds the stages that have no free slot behind them;
// empty stages keep taking requests.
module crc_checked_humidity_temperature_decode_unit import chtd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         temp_high_byte_i,
  input  logic [7:0]         temp_low_byte_i,
  input  logic [7:0]         temp_check_byte_i,
  input  logic [7:0]         hum_high_byte_i,
  input  logic [7:0]         hum_low_byte_i,
  input  logic [7:0]         hum_check_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               temp_positive_o,
  output logic [10:0]        temp_magnitude_tenths_o,
  output logic signed [11:0] temp_signed_tenths_o,
  output logic [9:0]         humidity_tenths_o,
  output logic               temp_check_ok_o,
  output logic               hum_check_ok_o
);

  logic [7:0]  poly_q;
  logic        s0_valid_q, s1_valid_q, s2_valid_q;
  logic        in_acc, s1_load, s2_load;
  chtd_frame_t frame_q;
  chtd_mid_t   mid;
  chtd_res_t   res;

  // polynomial register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  // stage advance, back-pressure from the output
  assign s2_load    = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign s1_load    = s0_valid_q && (!s1_valid_q || s2_load);
  assign in_ready_o = !s0_valid_q || s1_load;
  assign in_acc     = in_valid_i && in_ready_o;

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s0_valid_q <= 1'b1;
      end else if (s1_load) begin
        s0_valid_q <= 1'b0;
      end
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_q.t_hi  <= temp_high_byte_i;
      frame_q.t_lo  <= temp_low_byte_i;
      frame_q.t_chk <= temp_check_byte_i;
      frame_q.h_hi  <= hum_high_byte_i;
      frame_q.h_lo  <= hum_low_byte_i;
      frame_q.h_chk <= hum_check_byte_i;
    end
  end

  chtd_front u_front (
    .clk_i   (clk_i),
    .en_i    (s1_load),
    .poly_i  (poly_q),
    .frame_i (frame_q),
    .mid_o   (mid)
  );

  chtd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s2_load),
    .poly_i (poly_q),
    .mid_i  (mid),
    .res_o  (res)
  );

  // result ports
  assign out_valid_o             = s2_valid_q;
  assign temp_positive_o         = res.temp_positive;
  assign temp_magnitude_tenths_o = res.temp_magnitude;
  assign temp_signed_tenths_o    = res.temp_signed;
  assign humidity_tenths_o       = res.humidity;
  assign temp_check_ok_o         = res.temp_ok;
  assign hum_check_ok_o          = res.hum_ok;

endmodule

[rtl/chtd_front.sv]
// first pass: crc over the high bytes and scaling multiplies
module chtd_front import chtd_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [7:0]  poly_i,
  input  chtd_frame_t frame_i,
  output chtd_mid_t   mid_o
);

  chtd_mid_t mid_d, mid_q;

  // partial crc and products
  always_comb begin
    mid_d.t_crc    = crc8_byte(CrcInit, frame_i.t_hi, poly_i);
    mid_d.h_crc    = crc8_byte(CrcInit, frame_i.h_hi, poly_i);
    mid_d.t_lo     = frame_i.t_lo;
    mid_d.t_chk    = frame_i.t_chk;
    mid_d.h_lo     = frame_i.h_lo;
    mid_d.h_chk    = frame_i.h_chk;
    mid_d.t_scaled = 27'(TempScale) * 27'({frame_i.t_hi, frame_i.t_lo});
    mid_d.h_scaled = 26'(HumScale) * 26'({frame_i.h_hi, frame_i.h_lo});
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

[rtl/chtd_back.sv]
// second pass: crc check, conversion and held values in the output register
module chtd_back import chtd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] poly_i,
  input  chtd_mid_t  mid_i,
  output chtd_res_t  res_o
);

  chtd_res_t   res_d, res_q;
  logic        t_ok, h_ok, t_pos;
  logic [26:0] t_diff;
  logic [11:0] t_quot, h_quot;

  // finish crcs and compare
  assign t_ok = (crc8_byte(mid_i.t_crc, mid_i.t_lo, poly_i) == mid_i.t_chk);
  assign h_ok = (crc8_byte(mid_i.h_crc, mid_i.h_lo, poly_i) == mid_i.h_chk);

  // temperature offset and absolute value
  assign t_pos  = (mid_i.t_scaled >= TempOffset);
  assign t_diff = t_pos ? (mid_i.t_scaled - TempOffset) : (TempOffset - mid_i.t_scaled);
  assign t_quot = div_full_scale(t_diff);
  assign h_quot = div_full_scale(27'(mid_i.h_scaled));

  // update held values only where the crc matched; the crc flags follow every result
  always_comb begin
    res_d         = res_q;
    res_d.temp_ok = t_ok;
    res_d.hum_ok  = h_ok;
    if (t_ok) begin
      res_d.temp_positive  = t_pos;
      res_d.temp_magnitude = t_quot[10:0];
    end
    if (h_ok) begin
      res_d.humidity = h_quot[9:0];
    end
    if (res_d.temp_positive) begin
      res_d.temp_signed = signed'(12'(res_d.temp_magnitude));
    end else begin
      res_d.temp_signed = signed'(12'd0 - 12'(res_d.temp_magnitude));
    end
  end

  // held state doubles as output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/chtd_checker.sv]
// port-level checker for the decode unit, bound to the top level
`include "assert_macros.svh"

module chtd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               temp_positive_o,
  input logic [10:0]        temp_magnitude_tenths_o,
  input logic signed [11:0] temp_signed_tenths_o,
  input logic [9:0]         humidity_tenths_o,
  input logic               temp_check_ok_o,
  input logic               hum_check_ok_o
);

  logic new_res;
  logic out_valid_q, out_ready_q;

  // output handshake of the previous cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_ready_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_o;
      out_ready_q <= out_ready_i;
    end
  end

  // a fresh result enters the output this cycle
  assign new_res = out_valid_o && (!out_valid_q || out_ready_q);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(temp_magnitude_tenths_o) && $stable(humidity_tenths_o) && $stable(temp_check_ok_o), "stalled result changed")

  // with an empty output the pipeline always takes a request
  `ASSERT_IMPLY(a_ready_empty, clk_i, rst_ni, !out_valid_o, in_ready_o, "request refused with empty output")

  // signed value agrees with sign and magnitude
  `ASSERT_IMPLY(a_signed, clk_i, rst_ni, out_valid_o, $unsigned(temp_signed_tenths_o) == (temp_positive_o ? 12'(temp_magnitude_tenths_o) : 12'd0 - 12'(temp_magnitude_tenths_o)), "signed temperature mismatch")

  // failed temperature crc keeps the held temperature
  `ASSERT_IMPLY(a_temp_keep, clk_i, rst_ni, new_res && !temp_check_ok_o, temp_magnitude_tenths_o == $past(temp_magnitude_tenths_o) && temp_positive_o == $past(temp_positive_o), "temperature changed on crc failure")

  // failed humidity crc keeps the held humidity
  `ASSERT_IMPLY(a_hum_keep, clk_i, rst_ni, new_res && !hum_check_ok_o, humidity_tenths_o == $past(humidity_tenths_o), "humidity changed on crc failure")

endmodule

bind crc_checked_humidity_temperature_decode_unit chtd_checker u_chtd_checker (.*);
